// ----- design/frm_pkg.sv -----
package frm_pkg;

   localparam int DATA_WIDTH  = 64;
   localparam int ID_WIDTH    = 32;
   localparam int RATE_WIDTH  = 16;
   localparam int WL_WIDTH    = 32;
   localparam int COUNT_WIDTH = 6;
   localparam int SCALE_WIDTH = 24;

   localparam logic [SCALE_WIDTH-1:0] TENTHS_SCALE  = 24'd10000000;
   localparam logic [WL_WIDTH-1:0]    WINDOW_RESET  = 32'd500000;
   localparam logic [ID_WIDTH-1:0]    COUNTER_RESET = 32'd4;

   localparam logic CSR_ACTIVE        = 1'b0;
   localparam logic CSR_WINDOW_LENGTH = 1'b1;

   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_REPLY = 1'b1;

   typedef enum logic [2:0] {
      OUTCOME_IGNORED = 3'd0,
      OUTCOME_HANDLED = 3'd1,
      OUTCOME_QUERY   = 3'd2,
      OUTCOME_METRICS = 3'd3,
      OUTCOME_ERROR   = 3'd4
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVAL,
      ST_DIVIDE,
      ST_FINISH
   } fsm_state_type;

   typedef struct packed {
      logic done;
      logic saturated;
   } div_status_type;

endpackage

// ----- design/frm_if.sv -----
interface frm_req_if import frm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [DATA_WIDTH-1:0] timestamp;
   logic [ID_WIDTH-1:0]   reply_id;
   logic                  reply_ok;
   logic [DATA_WIDTH-1:0] frame_count;

   modport source (output valid, req_type, timestamp, reply_id, reply_ok, frame_count,
                   input ready);
   modport sink (input valid, req_type, timestamp, reply_id, reply_ok, frame_count,
                 output ready);
endinterface

interface frm_rsp_if import frm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [2:0]            outcome;
   logic [ID_WIDTH-1:0]   query_id;
   logic [RATE_WIDTH-1:0] rate_tenths;
   logic [DATA_WIDTH-1:0] frames_shown;

   modport source (output valid, outcome, query_id, rate_tenths, frames_shown,
                   input ready);
   modport sink (input valid, outcome, query_id, rate_tenths, frames_shown,
                 output ready);
endinterface

// ----- design/frm_divider.sv -----
module frm_divider import frm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [DATA_WIDTH-1:0]  dividend,
   input  logic [DATA_WIDTH-1:0]  divisor,
   output div_status_type         status,
   output logic [RATE_WIDTH-1:0]  quotient
);

   localparam logic [COUNT_WIDTH-1:0] SAT_STEPS = COUNT_WIDTH'(DATA_WIDTH - RATE_WIDTH);

   logic [DATA_WIDTH-1:0]  rem_ff, rem_in;
   logic [DATA_WIDTH-1:0]  dvd_ff, dvd_in;
   logic [DATA_WIDTH-1:0]  dsr_ff, dsr_in;
   logic [RATE_WIDTH-1:0]  quo_ff, quo_in;
   logic                   sat_ff, sat_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic [DATA_WIDTH:0]    trial;
   logic [DATA_WIDTH:0]    trial_diff;
   logic                   q_bit;

   // restoring step: bring down the next dividend bit, subtract if it fits
   assign trial      = {rem_ff, dvd_ff[DATA_WIDTH-1]};
   assign q_bit      = (trial >= {1'b0, dsr_ff});
   assign trial_diff = trial - {1'b0, dsr_ff};

   always_comb begin
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      dsr_in   = dsr_ff;
      quo_in   = quo_ff;
      sat_in   = sat_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         dvd_in   = dividend;
         dsr_in   = divisor;
         quo_in   = '0;
         sat_in   = 1'b0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = q_bit ? trial_diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
         dvd_in   = {dvd_ff[DATA_WIDTH-2:0], 1'b0};
         quo_in   = {quo_ff[RATE_WIDTH-2:0], q_bit};
         // a one above the low quotient bits means the rate overflows
         sat_in   = sat_ff | (q_bit & (count_ff < SAT_STEPS));
         count_in = count_ff + 1'b1;
         if (&count_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      dsr_ff   <= dsr_in;
      quo_ff   <= quo_in;
      sat_ff   <= sat_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.done      = done_ff;
   assign status.saturated = sat_ff;
   assign quotient         = quo_ff;

endmodule

// ----- design/frame_rate_meter.sv -----
// Frame rate meter. Each word on req_ch is a timer tick or a reply to a frame count
// query and gives exactly one word on rsp_ch. Operands pass LSB first through a
// bit-serial scan (subtractors, comparators and a serial-parallel multiply by 10^7);
// a reply that yields a new rate then also runs the 64-step restoring divider. The
// word's result register loads in the finish state, which waits while rsp_ch still
// holds the previous result; req_ch is ready again after that. req_ch is ready
// whenever the block is between words, even while the previous result still waits
// on rsp_ch. Configuration is written through csr_write_en, csr_index and
// csr_write_data; the user must write it only while idle, as the block does not
// enforce this.
module frame_rate_meter import frm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   frm_req_if.sink             req_ch,
   frm_rsp_if.source           rsp_ch,
   input  logic                csr_write_en,
   input  logic                csr_index,
   input  logic [WL_WIDTH-1:0] csr_write_data
);

   fsm_state_type state_ff, state_in;

   logic                   active_ff, active_in;
   logic [WL_WIDTH-1:0]    window_length_ff, window_length_in;

   logic [DATA_WIDTH-1:0]  window_start_ff, window_start_in;
   logic [DATA_WIDTH-1:0]  query_time_ff, query_time_in;
   logic [DATA_WIDTH-1:0]  sample_time_ff, sample_time_in;
   logic [DATA_WIDTH-1:0]  sample_frames_ff, sample_frames_in;
   logic [DATA_WIDTH-1:0]  frames_total_ff, frames_total_in;
   logic [RATE_WIDTH-1:0]  rate_value_ff, rate_value_in;
   logic [ID_WIDTH-1:0]    request_counter_ff, request_counter_in;
   logic                   query_open_ff, query_open_in;

   logic                   type_ff, type_in;
   logic [ID_WIDTH-1:0]    reply_id_ff, reply_id_in;
   logic                   reply_ok_ff, reply_ok_in;
   logic [DATA_WIDTH-1:0]  op_ff, op_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   borrow_a_ff, borrow_a_in;
   logic                   nz_a_ff, nz_a_in;
   logic                   ge_ff, ge_in;
   logic                   borrow_b_ff, borrow_b_in;
   logic                   nz_b_ff, nz_b_in;
   logic [SCALE_WIDTH-1:0] acc_ff, acc_in;
   logic [DATA_WIDTH-1:0]  prod_ff, prod_in;
   logic [DATA_WIDTH-1:0]  delta_ff, delta_in;
   logic [RATE_WIDTH-1:0]  rate_calc_ff, rate_calc_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   outcome_type            rsp_outcome_ff, rsp_outcome_in;
   logic [ID_WIDTH-1:0]    rsp_query_id_ff, rsp_query_id_in;
   logic [RATE_WIDTH-1:0]  rsp_rate_ff, rsp_rate_in;
   logic [DATA_WIDTH-1:0]  rsp_frames_ff, rsp_frames_in;

   // serial datapath
   logic                   sub_b_bit;
   logic                   diff_a;
   logic                   diff_b;
   logic                   wl_bit;
   logic [SCALE_WIDTH:0]   mul_sum;
   logic [ID_WIDTH-1:0]    counter_next;
   logic                   matched;
   logic                   tick_go;
   logic                   rate_ok;
   logic                   want_rate;
   logic                   out_free;
   logic                   div_start;
   div_status_type         div_status;
   logic [RATE_WIDTH-1:0]  div_quotient;

   assign sub_b_bit = (type_ff == REQ_REPLY) ? sample_frames_ff[0] : window_start_ff[0];
   assign diff_a    = op_ff[0] ^ sub_b_bit ^ borrow_a_ff;
   assign diff_b    = query_time_ff[0] ^ sample_time_ff[0] ^ borrow_b_ff;
   assign wl_bit    = ~count_ff[COUNT_WIDTH-1] & window_length_ff[count_ff[COUNT_WIDTH-2:0]];
   assign mul_sum   = {1'b0, acc_ff} + (diff_a ? {1'b0, TENTHS_SCALE} : '0);

   assign counter_next = ((request_counter_ff + 1'b1) == '0) ? ID_WIDTH'(1)
                                                             : request_counter_ff + 1'b1;
   assign matched   = query_open_ff && (reply_id_ff == request_counter_ff);
   assign tick_go   = nz_a_ff && !borrow_a_ff && ge_ff;
   assign rate_ok   = (sample_time_ff != '0) && !borrow_b_ff && nz_b_ff && !borrow_a_ff;
   assign want_rate = (type_ff == REQ_REPLY) && matched && reply_ok_ff && rate_ok;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   frm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (delta_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in           = state_ff;
      active_in          = active_ff;
      window_length_in   = window_length_ff;
      window_start_in    = window_start_ff;
      query_time_in      = query_time_ff;
      sample_time_in     = sample_time_ff;
      sample_frames_in   = sample_frames_ff;
      frames_total_in    = frames_total_ff;
      rate_value_in      = rate_value_ff;
      request_counter_in = request_counter_ff;
      query_open_in      = query_open_ff;
      type_in            = type_ff;
      reply_id_in        = reply_id_ff;
      reply_ok_in        = reply_ok_ff;
      op_in              = op_ff;
      count_in           = count_ff;
      borrow_a_in        = borrow_a_ff;
      nz_a_in            = nz_a_ff;
      ge_in              = ge_ff;
      borrow_b_in        = borrow_b_ff;
      nz_b_in            = nz_b_ff;
      acc_in             = acc_ff;
      prod_in            = prod_ff;
      delta_in           = delta_ff;
      rate_calc_in       = rate_calc_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ch.ready;
      rsp_outcome_in     = rsp_outcome_ff;
      rsp_query_id_in    = rsp_query_id_ff;
      rsp_rate_in        = rsp_rate_ff;
      rsp_frames_in      = rsp_frames_ff;
      div_start          = 1'b0;

      if (csr_write_en) begin
         if (csr_index == CSR_ACTIVE) begin
            active_in = csr_write_data[0];
         end else begin
            window_length_in = csr_write_data;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               type_in     = req_ch.req_type;
               reply_id_in = req_ch.reply_id;
               reply_ok_in = req_ch.reply_ok;
               op_in       = (req_ch.req_type == REQ_REPLY) ? req_ch.frame_count
                                                            : req_ch.timestamp;
               count_in    = '0;
               borrow_a_in = 1'b0;
               nz_a_in     = 1'b0;
               ge_in       = 1'b1;
               borrow_b_in = 1'b0;
               nz_b_in     = 1'b0;
               acc_in      = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            borrow_a_in = (~op_ff[0] & sub_b_bit) | (~op_ff[0] & borrow_a_ff)
                        | (sub_b_bit & borrow_a_ff);
            nz_a_in     = nz_a_ff | diff_a;
            if (diff_a != wl_bit) begin
               ge_in = diff_a;
            end
            borrow_b_in = (~query_time_ff[0] & sample_time_ff[0])
                        | (~query_time_ff[0] & borrow_b_ff)
                        | (sample_time_ff[0] & borrow_b_ff);
            nz_b_in     = nz_b_ff | diff_b;
            acc_in      = mul_sum[SCALE_WIDTH:1];
            prod_in     = {mul_sum[0], prod_ff[DATA_WIDTH-1:1]};
            delta_in    = {diff_b, delta_ff[DATA_WIDTH-1:1]};
            // rotate so every operand is back in place after a full pass
            op_in            = {op_ff[0], op_ff[DATA_WIDTH-1:1]};
            window_start_in  = {window_start_ff[0], window_start_ff[DATA_WIDTH-1:1]};
            sample_frames_in = {sample_frames_ff[0], sample_frames_ff[DATA_WIDTH-1:1]};
            query_time_in    = {query_time_ff[0], query_time_ff[DATA_WIDTH-1:1]};
            sample_time_in   = {sample_time_ff[0], sample_time_ff[DATA_WIDTH-1:1]};
            count_in         = count_ff + 1'b1;
            if (&count_ff) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (want_rate) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               rate_calc_in = div_status.saturated ? '1 : div_quotient;
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_outcome_in  = OUTCOME_IGNORED;
               rsp_query_id_in = '0;
               if (type_ff == REQ_TICK) begin
                  if (active_ff) begin
                     rsp_outcome_in = OUTCOME_HANDLED;
                     if (window_start_ff == '0) begin
                        window_start_in = op_ff;
                     end else if (tick_go) begin
                        window_start_in = op_ff;
                        if (!query_open_ff) begin
                           request_counter_in = counter_next;
                           query_time_in      = op_ff;
                           query_open_in      = 1'b1;
                           rsp_outcome_in     = OUTCOME_QUERY;
                           rsp_query_id_in    = counter_next;
                        end
                     end
                  end
               end else if (matched) begin
                  query_open_in = 1'b0;
                  if (!reply_ok_ff) begin
                     rsp_outcome_in = OUTCOME_ERROR;
                  end else begin
                     if (rate_ok) begin
                        rate_value_in = rate_calc_ff;
                     end
                     sample_time_in   = query_time_ff;
                     sample_frames_in = op_ff;
                     frames_total_in  = op_ff;
                     rsp_outcome_in   = OUTCOME_METRICS;
                  end
               end
               rsp_rate_in   = rate_value_in;
               rsp_frames_in = frames_total_in;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      type_ff         <= type_in;
      reply_id_ff     <= reply_id_in;
      reply_ok_ff     <= reply_ok_in;
      op_ff           <= op_in;
      count_ff        <= count_in;
      borrow_a_ff     <= borrow_a_in;
      nz_a_ff         <= nz_a_in;
      ge_ff           <= ge_in;
      borrow_b_ff     <= borrow_b_in;
      nz_b_ff         <= nz_b_in;
      acc_ff          <= acc_in;
      prod_ff         <= prod_in;
      delta_ff        <= delta_in;
      rate_calc_ff    <= rate_calc_in;
      rsp_outcome_ff  <= rsp_outcome_in;
      rsp_query_id_ff <= rsp_query_id_in;
      rsp_rate_ff     <= rsp_rate_in;
      rsp_frames_ff   <= rsp_frames_in;
      if (reset) begin
         state_ff           <= ST_IDLE;
         active_ff          <= 1'b0;
         window_length_ff   <= WINDOW_RESET;
         window_start_ff    <= '0;
         query_time_ff      <= '0;
         sample_time_ff     <= '0;
         sample_frames_ff   <= '0;
         frames_total_ff    <= '0;
         rate_value_ff      <= '0;
         request_counter_ff <= COUNTER_RESET;
         query_open_ff      <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         active_ff          <= active_in;
         window_length_ff   <= window_length_in;
         window_start_ff    <= window_start_in;
         query_time_ff      <= query_time_in;
         sample_time_ff     <= sample_time_in;
         sample_frames_ff   <= sample_frames_in;
         frames_total_ff    <= frames_total_in;
         rate_value_ff      <= rate_value_in;
         request_counter_ff <= request_counter_in;
         query_open_ff      <= query_open_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.outcome     = rsp_outcome_ff;
   assign rsp_ch.query_id    = rsp_query_id_ff;
   assign rsp_ch.rate_tenths = rsp_rate_ff;
   assign rsp_ch.frames_shown = rsp_frames_ff;

   a_id_nonzero: assert property (@(posedge clock) disable iff (reset)
      request_counter_ff != '0)
      else $error("request counter reached zero");

   a_query_has_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_outcome_ff == OUTCOME_QUERY) |-> rsp_query_id_ff != '0)
      else $error("query issued with a zero id");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside the divide phase");

   a_open_with_query: assert property (@(posedge clock) disable iff (reset)
      $rose(query_open_ff) |-> (rsp_valid_ff && rsp_outcome_ff == OUTCOME_QUERY))
      else $error("query opened without a query word");

endmodule

// ----- sim/tb_frame_rate_meter.sv -----
module tb_frame_rate_meter;
   timeunit 1ns;
   timeprecision 1ps;

   import frm_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int STALL_PCT     = 31;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 200;
   localparam int PHASES        = 12;
   localparam int PHASE_WORDS   = 170;
   localparam int MAX_REPORTS   = 10;

   typedef struct {
      logic                  req_type;
      logic [DATA_WIDTH-1:0] timestamp;
      logic [ID_WIDTH-1:0]   reply_id;
      logic                  reply_ok;
      logic [DATA_WIDTH-1:0] frame_count;
   } req_word_type;

   typedef struct {
      logic [2:0]            outcome;
      logic [ID_WIDTH-1:0]   query_id;
      logic [RATE_WIDTH-1:0] rate_tenths;
      logic [DATA_WIDTH-1:0] frames_shown;
   } rsp_word_type;

   // Tracks the meter's window, open query and sample point, and queues the
   // response each accepted word should produce.
   class rate_ledger;
      bit                    active;
      logic [WL_WIDTH-1:0]   window_length;
      logic [DATA_WIDTH-1:0] window_start;
      logic [DATA_WIDTH-1:0] query_time;
      logic [DATA_WIDTH-1:0] sample_time;
      logic [DATA_WIDTH-1:0] sample_frames;
      logic [DATA_WIDTH-1:0] frames_total;
      logic [RATE_WIDTH-1:0] rate_value;
      logic [ID_WIDTH-1:0]   req_counter;
      bit                    query_open;
      rsp_word_type          awaited[$];
      int                    mismatches;

      function new();
         active        = 1'b0;
         window_length = WINDOW_RESET;
         window_start  = '0;
         query_time    = '0;
         sample_time   = '0;
         sample_frames = '0;
         frames_total  = '0;
         rate_value    = '0;
         req_counter   = COUNTER_RESET;
         query_open    = 1'b0;
         mismatches    = 0;
      endfunction

      function void write_reg(logic index, logic [WL_WIDTH-1:0] value);
         if (index == CSR_ACTIVE) begin
            active = value[0];
         end else begin
            window_length = value;
         end
      endfunction

      function void note_word(req_word_type w);
         rsp_word_type          want;
         logic [DATA_WIDTH-1:0] product;
         logic [DATA_WIDTH-1:0] quotient;
         want.outcome  = OUTCOME_IGNORED;
         want.query_id = '0;
         if (w.req_type == REQ_TICK) begin
            if (active) begin
               want.outcome = OUTCOME_HANDLED;
               if (window_start == 0) begin
                  window_start = w.timestamp;
               end else if (w.timestamp > window_start &&
                            w.timestamp - window_start >= {32'b0, window_length}) begin
                  window_start = w.timestamp;
                  if (!query_open) begin
                     req_counter = req_counter + 1;
                     // ids are never zero
                     if (req_counter == 0) begin
                        req_counter = 1;
                     end
                     query_time    = w.timestamp;
                     query_open    = 1'b1;
                     want.outcome  = OUTCOME_QUERY;
                     want.query_id = req_counter;
                  end
               end
            end
         end else if (query_open && w.reply_id == req_counter) begin
            query_open = 1'b0;
            if (!w.reply_ok) begin
               want.outcome = OUTCOME_ERROR;
            end else begin
               if (sample_time != 0 && query_time > sample_time &&
                   w.frame_count >= sample_frames) begin
                  product    = (w.frame_count - sample_frames) * TENTHS_SCALE;
                  quotient   = product / (query_time - sample_time);
                  rate_value = (quotient > 64'd65535) ? 16'hFFFF : quotient[15:0];
               end
               sample_time   = query_time;
               sample_frames = w.frame_count;
               frames_total  = w.frame_count;
               want.outcome  = OUTCOME_METRICS;
            end
         end
         want.rate_tenths  = rate_value;
         want.frames_shown = frames_total;
         awaited.push_back(want);
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("%0t: rsp word with nothing awaited: outcome %0d id %0h",
                        $time, got.outcome, got.query_id);
               $display("   rate %0d frames %0h", got.rate_tenths, got.frames_shown);
            end
            return;
         end
         want = awaited.pop_front();
         if (got.outcome !== want.outcome || got.query_id !== want.query_id ||
             got.rate_tenths !== want.rate_tenths ||
             got.frames_shown !== want.frames_shown) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("%0t: rsp mismatch: outcome %0d/%0d id %0h/%0h",
                        $time, want.outcome, got.outcome, want.query_id, got.query_id);
               $display("   rate %0d/%0d frames %0h/%0h",
                        want.rate_tenths, got.rate_tenths, want.frames_shown,
                        got.frames_shown);
            end
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                csr_write_en;
   logic                csr_index;
   logic [WL_WIDTH-1:0] csr_write_data;
   bit                  steady;
   int unsigned         cycles;
   rate_ledger          ledger = new();

   frm_req_if req_ch();
   frm_rsp_if rsp_ch();

   frame_rate_meter u_top (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= steady || ($urandom_range(99) >= STALL_PCT);
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         ledger.check_word(rsp_word_type'{rsp_ch.outcome, rsp_ch.query_id,
                                          rsp_ch.rate_tenths, rsp_ch.frames_shown});
      end
   end

   // Entered and left on a falling edge; valid stays high on return.
   task automatic send_word(input req_word_type w);
      while (!steady && $urandom_range(99) < STALL_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.req_type    <= w.req_type;
      req_ch.timestamp   <= w.timestamp;
      req_ch.reply_id    <= w.reply_id;
      req_ch.reply_ok    <= w.reply_ok;
      req_ch.frame_count <= w.frame_count;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      ledger.note_word(w);
      @(negedge clock);
   endtask

   task automatic tick(input logic [DATA_WIDTH-1:0] ts);
      req_word_type w;
      w.req_type    = REQ_TICK;
      w.timestamp   = ts;
      w.reply_id    = $urandom;
      w.reply_ok    = 1'($urandom_range(1));
      w.frame_count = {$urandom, $urandom};
      send_word(w);
   endtask

   task automatic reply(input logic [ID_WIDTH-1:0] id, input logic ok,
                        input logic [DATA_WIDTH-1:0] frames);
      req_word_type w;
      w.req_type    = REQ_REPLY;
      w.timestamp   = {$urandom, $urandom};
      w.reply_id    = id;
      w.reply_ok    = ok;
      w.frame_count = frames;
      send_word(w);
   endtask

   task automatic answer(input logic ok, input logic [DATA_WIDTH-1:0] frames);
      reply(ledger.req_counter, ok, frames);
   endtask

   task automatic write_reg(input logic index, input logic [WL_WIDTH-1:0] value);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      ledger.write_reg(index, value);
      @(negedge clock);
   endtask

   // Hold the sender until every response is in and the block has gone quiet.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (ledger.awaited.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      bit                    act_plan[PHASES] = '{1, 0, 1, 1, 1, 0, 1, 1, 1, 1, 0, 1};
      logic [WL_WIDTH-1:0]   wl_plan[PHASES]  = '{1, 500000, 500000, 32'hFFFF_FFFF, 16667, 0,
                                                  250000, 1000, 0, 1000000, 7, 33333};
      logic [DATA_WIDTH-1:0] now;
      int unsigned           span;
      int unsigned           pick;

      reset              = 1'b1;
      csr_write_en       = 1'b0;
      csr_index          = CSR_ACTIVE;
      csr_write_data     = '0;
      req_ch.valid       = 1'b0;
      req_ch.req_type    = REQ_TICK;
      req_ch.timestamp   = '0;
      req_ch.reply_id    = '0;
      req_ch.reply_ok    = 1'b0;
      req_ch.frame_count = '0;
      steady             = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // inactive block: ticks ignored, nothing open to answer
      tick('1);
      tick('0);
      reply('1, 1'b1, '1);
      reply('0, 1'b0, '0);
      settle();

      write_reg(CSR_ACTIVE, 1);
      write_reg(CSR_WINDOW_LENGTH, 0);
      tick(64'd0);                   // window stays unstarted
      tick(64'd1000);                // starts the window
      tick(64'd1000);                // not past the start
      tick(64'd999);                 // time going backwards
      tick(64'd1001);                // zero window restarts and queries
      tick(64'd1500);                // query still open
      reply(ledger.req_counter + 1, 1'b1, 64'd5);
      answer(1'b0, 64'd7);           // failed reply
      tick(64'd2000);
      answer(1'b1, 64'd100);         // no sample point yet
      settle();

      write_reg(CSR_WINDOW_LENGTH, WINDOW_RESET);
      tick(64'd501999);              // one short of the window
      tick(64'd502000);
      answer(1'b1, 64'd50);          // count below the sample
      tick(64'd1002000);
      answer(1'b1, 64'd60);
      tick(64'd1502000);
      answer(1'b1, 64'd1000060);     // saturates
      tick(64'd2002000);
      answer(1'b1, 64'd1000060 + 64'h8000_0000_0000_0001);  // product wraps
      now = 64'd2002000;
      settle();

      for (int p = 0; p < PHASES; p++) begin
         write_reg(CSR_ACTIVE, WL_WIDTH'(act_plan[p]));
         write_reg(CSR_WINDOW_LENGTH, wl_plan[p]);
         steady = (p == 6 || p == 7);
         span   = (wl_plan[p] < 1000) ? 1000 : wl_plan[p];
         for (int n = 0; n < PHASE_WORDS; n++) begin
            pick = $urandom_range(99);
            if (!act_plan[p]) begin
               // ignored ticks carry full-range timestamps safely
               if (pick < 60) begin
                  tick({$urandom, $urandom});
               end else begin
                  reply($urandom, 1'($urandom_range(1)), {$urandom, $urandom});
               end
            end else if (ledger.query_open && pick < 40) begin
               pick = $urandom_range(99);
               if (pick < 80) begin
                  answer($urandom_range(99) < 88, ledger.sample_frames + $urandom_range(4000));
               end else if (pick < 90) begin
                  answer($urandom_range(99) < 88, ledger.sample_frames - $urandom_range(100, 1));
               end else begin
                  answer($urandom_range(99) < 88, {$urandom, $urandom});
               end
            end else if (pick < 85) begin
               if ($urandom_range(99) < 90) begin
                  now = now + 64'($urandom_range(span)) + 64'($urandom_range(span));
                  tick(now);
               end else begin
                  tick(now - $urandom_range(1000));
               end
            end else if (pick < 93) begin
               reply($urandom, 1'($urandom_range(1)), {$urandom, $urandom});
            end else begin
               reply(ledger.req_counter - 1, 1'b1, ledger.sample_frames + $urandom_range(100));
            end
            if (n == PHASE_WORDS / 2 && p % 3 == 1) begin
               settle();
            end
         end
         settle();
      end
      steady = 1'b0;

      // top of the timestamp range closes the run, as the window cannot move on
      write_reg(CSR_ACTIVE, 1);
      write_reg(CSR_WINDOW_LENGTH, '1);
      if (ledger.query_open) begin
         answer(1'b1, ledger.sample_frames + 64'd30);
      end
      tick('1);
      answer(1'b1, '1);
      tick('1);
      settle();

      if (ledger.mismatches == 0 && ledger.awaited.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
